FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent-check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("%m: check failed");
`define ASSERT_NEVER(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(cond)) else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hdl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Types and constants shared by the Hill cipher encrypt unit.
// ----------------------------------------------------------------------------
package hce_pkg;

	localparam int unsigned BLOCK_N     = 3;   // letters per block, 2..4
	localparam int unsigned LTR_W       = 5;   // letter index width
	localparam int unsigned CHAR_W      = 7;   // ASCII width
	localparam int unsigned KEY_W       = 20;
	localparam int unsigned KEY_ROWS    = 4;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned ALPHABET    = 26;
	localparam int unsigned LETTER_BASE = 97;

	localparam int unsigned ROW_W = (BLOCK_N > 1) ? $clog2(BLOCK_N) : 1;
	localparam int unsigned CNT_W = ROW_W;

	// row sum: up to BLOCK_N products of two 5-bit values
	localparam int unsigned SUM_MAX = BLOCK_N * 31 * 31;
	localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
	// quotient estimate x*RECIP >> RECIP_SH is floor(x/26) or one below it
	localparam int unsigned RECIP    = 2520;
	localparam int unsigned RECIP_W  = 12;
	localparam int unsigned RECIP_SH = 16;
	localparam int unsigned Q_W      = SUM_W - 4;
	localparam int unsigned REM_W    = 6;      // remainder before fix-up, < 52

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [LTR_W-1:0]        ltr_t;
	typedef ltr_t [BLOCK_N-1:0]      blk_t;
	typedef logic [KEY_W-1:0]        key_row_t;
	typedef key_row_t [BLOCK_N-1:0]  key_mat_t;

	typedef struct packed {
		logic vld;
		blk_t blk;
	} push_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

FILE: hdl/hill_cipher_encrypt_unit.sv
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit
// Hill cipher encryptor, BLOCK_N x BLOCK_N key, lowercase ASCII in and out.
// ----------------------------------------------------------------------------
// Takes one plaintext letter per cycle unless plain_stall is raised.
// Letters are gathered into blocks of BLOCK_N; a completed block goes
// into a two-entry queue, and the matrix engine drains it one key row per
// cycle unless cipher_stall holds the output, so a block's BLOCK_N
// ciphertext letters leave one per cycle and the sustained rate is one
// letter in and one out per cycle. The first letter of a block passes the
// queue write, then the row sum, quotient estimate and remainder/output
// registers; block_end marks each block's last letter. Key rows are written
// via wr_en / wr_index / wr_data, entry c of a row in bits 5c+4..5c; the
// user must write them only while the unit is idle, which is not enforced.
module hill_cipher_encrypt_unit import hce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [KEY_W-1:0]     wr_data,
	input  logic                 plain_valid,
	output logic                 plain_stall,
	input  logic [CHAR_W-1:0]    plain_letter,
	output logic                 cipher_valid,
	input  logic                 cipher_stall,
	output logic [CHAR_W-1:0]    cipher_letter,
	output logic                 block_end
);

	key_row_t key_q [KEY_ROWS];
	key_mat_t key;
	push_t    push;
	q_stat_t  q_stat;
	blk_t     head;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KEY_ROWS; r++) begin
				key_q[r] <= '0;
			end
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
		end
	end

	always_comb begin
		for (int r = 0; r < BLOCK_N; r++) begin
			key[r] = key_q[r];
		end
	end

	hce_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.plain_valid  (plain_valid),
		.plain_stall  (plain_stall),
		.plain_letter (plain_letter),
		.q_stat       (q_stat),
		.push         (push)
	);

	hce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.q_stat (q_stat),
		.head   (head)
	);

	hce_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.key           (key),
		.q_stat        (q_stat),
		.head          (head),
		.pop           (pop),
		.cipher_valid  (cipher_valid),
		.cipher_stall  (cipher_stall),
		.cipher_letter (cipher_letter),
		.block_end     (block_end)
	);

endmodule

FILE: hdl/hce_front.sv
// ----------------------------------------------------------------------------
// hce_front
// Takes plaintext letters, maps them to 0..25 and gathers a full block.
// ----------------------------------------------------------------------------
module hce_front import hce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plain_valid,
	output logic              plain_stall,
	input  logic [CHAR_W-1:0] plain_letter,
	input  q_stat_t           q_stat,
	output push_t             push
);

	ltr_t             held_q [BLOCK_N-1];
	logic [CNT_W-1:0] cnt_q;
	ltr_t             ltr;
	logic             accept;
	logic             completes;

	assign ltr         = LTR_W'(plain_letter - CHAR_W'(LETTER_BASE));
	assign completes   = (cnt_q == CNT_W'(BLOCK_N - 1));
	assign plain_stall = completes && q_stat.full;
	assign accept      = plain_valid && !plain_stall;

	always_comb begin
		push.vld = accept && completes;
		for (int k = 0; k < BLOCK_N - 1; k++) begin
			push.blk[k] = held_q[k];
		end
		push.blk[BLOCK_N-1] = ltr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (completes) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// shift line: oldest letter ends up in entry 0
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < BLOCK_N - 2; i++) begin
				held_q[i] <= held_q[i+1];
			end
			held_q[BLOCK_N-2] <= ltr;
		end
	end

endmodule

FILE: hdl/hce_queue.sv
// ----------------------------------------------------------------------------
// hce_queue
// Short block queue between the letter gatherer and the matrix engine.
// ----------------------------------------------------------------------------
module hce_queue import hce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output q_stat_t q_stat,
	output blk_t    head
);

`include "assert_macros.svh"

	blk_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full     = (cnt_q == QCNT_W'(QDEPTH));
	assign q_stat.nonempty = (cnt_q != '0);
	assign head            = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.vld) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push.vld && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push.vld) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			slot_q[wr_ptr_q] <= push.blk;
		end
	end

	`ASSERT_NEVER(a_no_push_full, push.vld && q_stat.full)
	`ASSERT_NEVER(a_no_pop_empty, pop && !q_stat.nonempty)
	`ASSERT_AT(a_cnt_grows, push.vld && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))

endmodule

FILE: hdl/hce_back.sv
// ----------------------------------------------------------------------------
// hce_back
// Matrix engine: one key row per cycle unless stalled, mod 26 reduction, output register.
// ----------------------------------------------------------------------------
module hce_back import hce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  key_mat_t          key,
	input  q_stat_t           q_stat,
	input  blk_t              head,
	output logic              pop,
	output logic              cipher_valid,
	input  logic              cipher_stall,
	output logic [CHAR_W-1:0] cipher_letter,
	output logic              block_end
);

	logic [ROW_W-1:0] row_q;
	logic             en;
	logic             issue;
	logic             row_last;
	logic [SUM_W-1:0] row_sum;

	logic             vld_s1, last_s1;
	logic [SUM_W-1:0] sum_s1;
	logic             vld_s2, last_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [Q_W-1:0]   q_s2;

	logic [SUM_W+RECIP_W-1:0] q_prod;
	logic [SUM_W-1:0]         rem_full;
	logic [REM_W-1:0]         rem_raw;
	logic [LTR_W-1:0]         rem;

	logic              out_vld_q;
	logic              out_end_q;
	logic [CHAR_W-1:0] out_ltr_q;

	assign en       = !out_vld_q || !cipher_stall;
	assign issue    = en && q_stat.nonempty;
	assign row_last = (row_q == ROW_W'(BLOCK_N - 1));
	assign pop      = issue && row_last;

	always_comb begin
		row_sum = '0;
		for (int k = 0; k < BLOCK_N; k++) begin
			row_sum = row_sum + SUM_W'(key[row_q][LTR_W*k +: LTR_W]) * SUM_W'(head[k]);
		end
	end

	assign q_prod   = (SUM_W+RECIP_W)'(sum_s1) * (SUM_W+RECIP_W)'(RECIP);
	assign rem_full = sum_s2 - SUM_W'(q_s2) * SUM_W'(ALPHABET);
	assign rem_raw  = rem_full[REM_W-1:0];
	// quotient estimate may be one short
	assign rem      = (rem_raw >= REM_W'(ALPHABET)) ? LTR_W'(rem_raw - REM_W'(ALPHABET))
	                                                : LTR_W'(rem_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= issue;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
			if (issue) begin
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1    <= row_sum;
			last_s1   <= row_last;
			sum_s2    <= sum_s1;
			q_s2      <= q_prod[RECIP_SH +: Q_W];
			last_s2   <= last_s1;
			out_ltr_q <= CHAR_W'(rem) + CHAR_W'(LETTER_BASE);
			out_end_q <= last_s2;
		end
	end

	assign cipher_valid  = out_vld_q;
	assign cipher_letter = out_ltr_q;
	assign block_end     = out_end_q;

endmodule
